@@ hdl/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfa_pkg: shared types and codes for the bitmap page frame allocator
// Item and result payloads, operation and status codes, and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;

  localparam logic [WORD_BITS-1:0] WORD_FULL = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BELOW_KERNEL = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write one all-ones word of the clearing pass
    logic load;        // latch a new item
    logic scan;        // issue the next scan read
    logic fetch;       // read the word that holds the addressed frame
    logic commit;      // write back the word, update counters, post result
    logic finish;      // post a result with no change
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_alloc;
    logic is_nop;
    logic check_ok;
    logic scan_hit;
    logic scan_end;
  } ctrl_sts_t;

endpackage

@@ hdl/bpfa_ram.sv @@
// ----------------------------------------------------------------------------
// bpfa_ram: generic simple dual-port RAM
// One write port, one read port, registered read data held while idle.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic                                           re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpfa_ctrl: allocator sequencer
// Runs the clearing pass, then steps each item through check, scan or
// read-modify-write, and result.
// ----------------------------------------------------------------------------
module bpfa_ctrl import bpfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ctrl_sts_t sts,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_alloc) begin
          cmd.scan   = 1'b1;
          state_next = S_SCAN;
        end else if (!sts.is_nop && sts.check_ok) begin
          cmd.fetch  = 1'b1;
          state_next = S_APPLY;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (sts.scan_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

@@ hdl/bpfa_dp.sv @@
// ----------------------------------------------------------------------------
// bpfa_dp: allocator datapath
// Bitmap RAM, item and config registers, address checks, lowest-clear-bit
// encoder, saturating frame counters and the result register.
// ----------------------------------------------------------------------------
module bpfa_dp import bpfa_pkg::*; #(
  parameter int MAP_WORDS       = 1024,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  input  in_item_t           item,
  input  logic               cfg_wr,
  input  logic [COUNT_W-1:0] cfg_data,
  output out_item_t          result,
  output logic               done
);

  localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW          = $clog2(MAP_WORDS + 1);
  localparam int FW          = AW + BIT_IDX_W;
  localparam int FRAME_COUNT = MAP_WORDS * WORD_BITS;
  localparam int CNTW        = $clog2(FRAME_COUNT + 1);
  localparam int PW          = FW + PAGE_BYTES_LOG2;

  localparam logic [CNTW-1:0] CNT_MAX   = CNTW'(FRAME_COUNT);
  localparam logic [AW-1:0]   LAST_WORD = AW'(MAP_WORDS - 1);

  // Item and config registers
  in_item_t           item_q;
  logic [COUNT_W-1:0] kernel_end;

  // Clearing pass and scan bookkeeping
  logic [AW-1:0] clr_ptr;
  logic [CW-1:0] scan_cnt;
  logic          rd_valid;
  logic [AW-1:0] rd_word;

  // Counters
  logic [CNTW-1:0] free_cnt;
  logic [CNTW-1:0] total_cnt;
  logic [CNTW-1:0] free_next;
  logic [CNTW-1:0] total_next;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Address checks
  logic [ADDR_W-1:0]    frame_wide;
  logic                 aligned;
  logic                 in_range;
  logic                 below;
  logic [AW-1:0]        frame_word;
  logic [BIT_IDX_W-1:0] frame_bit;
  logic [STATUS_W-1:0]  fail_status;
  logic [STATUS_W-1:0]  res_status;

  // Lowest clear bit
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_onehot;
  logic [BIT_IDX_W-1:0] low_idx;
  logic [FW-1:0]        alloc_frame;
  logic [PW-1:0]        page_wide;
  logic                 scan_issue;

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign frame_wide = item_q.address >> PAGE_BYTES_LOG2;
  assign aligned    = (item_q.address[PAGE_BYTES_LOG2-1:0] == '0);
  assign in_range   = (frame_wide < ADDR_W'(FRAME_COUNT));
  assign below      = (item_q.operation == OP_ADD) && (frame_wide < ADDR_W'(kernel_end));
  assign frame_word = frame_wide[BIT_IDX_W +: AW];
  assign frame_bit  = frame_wide[BIT_IDX_W-1:0];

  always_comb begin
    if (!aligned) begin
      fail_status = ST_MISALIGNED;
    end else if (!in_range) begin
      fail_status = ST_RANGE;
    end else begin
      fail_status = ST_BELOW_KERNEL;
    end
  end

  // Status posted with a result
  always_comb begin
    res_status = ST_OK;
    if (cmd.finish) begin
      if (item_q.operation == OP_ALLOC) begin
        res_status = ST_NO_MEMORY;
      end else if (item_q.operation != OP_NOP) begin
        res_status = fail_status;
      end
    end
  end

  // Isolate the lowest zero bit of the word just read
  assign free_bits  = ~ram_rdata;
  assign low_onehot = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | BIT_IDX_W'(i);
      end
    end
  end

  assign alloc_frame = {rd_word, low_idx};
  assign page_wide   = PW'(alloc_frame) << PAGE_BYTES_LOG2;

  assign scan_issue = cmd.scan && (scan_cnt < CW'(MAP_WORDS));

  // RAM port selection
  always_comb begin
    ram_re    = scan_issue || cmd.fetch;
    ram_raddr = cmd.fetch ? frame_word : scan_cnt[AW-1:0];
    ram_we    = cmd.clear_step || cmd.commit;
    if (cmd.clear_step) begin
      ram_waddr = clr_ptr;
      ram_wdata = WORD_FULL;
    end else if (item_q.operation == OP_ALLOC) begin
      ram_waddr = rd_word;
      ram_wdata = ram_rdata | low_onehot;
    end else begin
      ram_waddr = frame_word;
      ram_wdata = ram_rdata & ~(WORD_BITS'(1) << frame_bit);
    end
  end

  // Counter updates for a committed item
  always_comb begin
    free_next  = free_cnt;
    total_next = total_cnt;
    if (cmd.commit) begin
      unique case (item_q.operation)
        OP_ALLOC: begin
          if (free_cnt != '0) begin
            free_next = free_cnt - CNTW'(1);
          end
        end
        OP_FREE: begin
          if (free_cnt != CNT_MAX) begin
            free_next = free_cnt + CNTW'(1);
          end
        end
        OP_ADD: begin
          if (free_cnt != CNT_MAX) begin
            free_next = free_cnt + CNTW'(1);
          end
          if (total_cnt != CNT_MAX) begin
            total_next = total_cnt + CNTW'(1);
          end
        end
        default: begin
          free_next = free_cnt;
        end
      endcase
    end
  end

  always_comb begin
    sts.clear_last = (clr_ptr == LAST_WORD);
    sts.is_alloc   = (item_q.operation == OP_ALLOC);
    sts.is_nop     = (item_q.operation == OP_NOP);
    sts.check_ok   = aligned && in_range && !below;
    sts.scan_hit   = rd_valid && (ram_rdata != WORD_FULL);
    sts.scan_end   = rd_valid && (ram_rdata == WORD_FULL) && (rd_word == LAST_WORD);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end <= '0;
      clr_ptr    <= '0;
      scan_cnt   <= '0;
      rd_valid   <= 1'b0;
      free_cnt   <= '0;
      total_cnt  <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        kernel_end <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (cmd.load) begin
        scan_cnt <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= scan_issue;
        if (scan_issue) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
      end
      free_cnt  <= free_next;
      total_cnt <= total_next;
      done      <= cmd.commit || cmd.finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.scan) begin
      rd_word <= scan_cnt[AW-1:0];
    end
    if (cmd.commit || cmd.finish) begin
      result.page_address <= (cmd.commit && (item_q.operation == OP_ALLOC)) ?
                             ADDR_W'(page_wide) : '0;
      result.status       <= res_status;
      result.free_count   <= COUNT_W'(free_next);
      result.total_count  <= COUNT_W'(total_next);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (free_cnt <= CNT_MAX) && (total_cnt <= CNT_MAX))
    else $error("frame counter past frame count");

  a_commit_alloc_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (item_q.operation == OP_ALLOC)) |-> sts.scan_hit)
    else $error("alloc commit without a clear bit");

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !(cmd.commit || cmd.load || cmd.finish))
    else $error("clearing pass overlaps item work");

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator: bitmap physical page frame allocator
// One bit per page frame (1 = used); alloc takes the lowest clear frame,
// free and add clear a frame after alignment, range and (add only) kernel checks.
//
//   channel  handshake              payload
//   -------  ---------------------  --------------------------------------
//   item     start / busy           item.operation, item.address
//   result   done (one-cycle pulse) result.page_address/status/counts
//   config   cfg_valid / cfg_ready  cfg_data (kernel end frame)
//
// Steps: alloc reads one bitmap word per cycle through the RAM read port,
//   from word 0 up and stops at the first word with a clear bit, or
//   after the last word when memory is full. Free and add go through
//   check, read and write back; errors and the unused code go from check
//   to the result. A new item may start in the cycle done is high.
// Reset: rst clears counters and kernel end, then a clearing pass writes
//   every bitmap word to all ones, one word per cycle, with busy high.
//   Config writes are taken at any time.
// Stalls: the receiver cannot stall; done lasts one cycle, result is held.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAP_WORDS       = 1024,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item,
  output logic               done,
  output out_item_t          result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Config register lives in the datapath; always ready
  assign cfg_ready = 1'b1;

  // Sequencer: clearing pass and per-item steps
  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Bitmap, counters and result register
  bpfa_dp #(
    .MAP_WORDS       (MAP_WORDS),
    .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .item     (item),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

  // Accepted item puts the block to work next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result only closes work that was under way
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without preceding work");

  // Results never come back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

endmodule

@@ dv/bitmap_page_frame_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_tb: self-checking bench for the frame allocator
// Drives alloc, free, add and no-op items through the start/busy port,
// keeps its own copy of the frame bitmap and counters to work out each
// result, and checks every done pulse field by field against the oldest
// outcome still owed. Covers empty memory, frame zero, address checks,
// kernel end limits, random traffic and repeated adds of one frame.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int MAP_WORDS  = 1024;
  localparam int PAGE_LOG2  = 12;
  localparam int FRAMES     = MAP_WORDS * WORD_BITS;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 90;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic               busy;
  in_item_t           item      = '0;
  logic               done;
  out_item_t          result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  // Shadow of the block: bitmap (1 = used), counters and kernel end
  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  int unsigned          free_ctr;
  int unsigned          total_ctr;
  logic [COUNT_W-1:0]   kernel_end_q;

  // Results owed by the block, oldest first
  out_item_t outcome_q [$];
  int        errors = 0;

  bitmap_page_frame_allocator #(
    .MAP_WORDS      (MAP_WORDS),
    .PAGE_BYTES_LOG2(PAGE_LOG2)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Hard stop well past the slowest legal run (full scans plus long gaps)
  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Apply one item to the shadow state and return the result it must give
  function automatic out_item_t frame_op_outcome(in_item_t it);
    out_item_t           r;
    logic [STATUS_W-1:0] st;
    int unsigned         frame;
    bit                  found;
    r     = '0;
    st    = ST_OK;
    frame = 0;
    found = 1'b0;
    case (it.operation)
      OP_ALLOC: begin
        // Walk words in order, skip full ones, take the lowest clear bit
        for (int w = 0; w < MAP_WORDS && !found; w++) begin
          if (frame_map[w] != WORD_FULL) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              if (!frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                frame = w * WORD_BITS + b;
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          // Hold the free count at zero rather than wrap
          if (free_ctr > 0) free_ctr--;
          r.page_address = 32'(frame << PAGE_LOG2);
        end else begin
          st = ST_NO_MEMORY;
        end
      end
      OP_FREE, OP_ADD: begin
        if (it.address[PAGE_LOG2-1:0] != '0) begin
          st = ST_MISALIGNED;
        end else if ((it.address >> PAGE_LOG2) >= FRAMES) begin
          st = ST_RANGE;
        end else begin
          frame = it.address >> PAGE_LOG2;
          if (it.operation == OP_ADD && frame < kernel_end_q) st = ST_BELOW_KERNEL;
        end
        if (st == ST_OK) begin
          // Clear even if already clear; counters still advance, capped
          frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
          free_ctr = (free_ctr < FRAMES) ? free_ctr + 1 : FRAMES;
          if (it.operation == OP_ADD)
            total_ctr = (total_ctr < FRAMES) ? total_ctr + 1 : FRAMES;
        end
      end
      default: ;
    endcase
    r.status      = st;
    r.free_count  = free_ctr[COUNT_W-1:0];
    r.total_count = total_ctr[COUNT_W-1:0];
    return r;
  endfunction

  // Check each done pulse against the oldest owed outcome
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $error("result with no item outstanding: %p", result);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (result.page_address !== want.page_address) begin
          $error("page_address: expected %h, got %h", want.page_address, result.page_address);
          errors++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.free_count !== want.free_count) begin
          $error("free_count: expected %0d, got %0d", want.free_count, result.free_count);
          errors++;
        end
        if (result.total_count !== want.total_count) begin
          $error("total_count: expected %0d, got %0d", want.total_count, result.total_count);
          errors++;
        end
      end
    end
  end

  // Present one item, hold it until taken, then drop start for the gap if one is given
  task automatic send_item(in_item_t it, int gap);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    outcome_q.push_back(frame_op_outcome(it));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    in_item_t it;
    it.operation = op;
    it.address   = addr;
    send_item(it, 0);
  endtask

  // Drop start and wait until every owed result has come back
  task automatic wait_idle();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the kernel end register; only called with the block idle
  task automatic write_kernel_end(logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    kernel_end_q = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly well-formed frame traffic in a low window, some deep frames,
  // and a tail of misaligned, out-of-range and no-op items
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned frame;
    it.operation = OP_ALLOC;
    it.address   = $urandom;
    pick  = $urandom_range(0, 99);
    frame = ($urandom_range(0, 9) == 0) ? $urandom_range(0, FRAMES - 1)
                                        : $urandom_range(0, 511);
    if (pick < 35) begin
      it.operation = OP_ALLOC;
    end else if (pick < 60) begin
      it.operation = OP_FREE;
      it.address   = 32'(frame << PAGE_LOG2);
    end else if (pick < 88) begin
      it.operation = OP_ADD;
      it.address   = 32'(frame << PAGE_LOG2);
    end else if (pick < 94) begin
      it.operation = $urandom_range(0, 1) ? OP_FREE : OP_ADD;
      if (it.address[PAGE_LOG2-1:0] == '0) it.address[0] = 1'b1;
    end else if (pick < 97) begin
      it.operation = $urandom_range(0, 1) ? OP_FREE : OP_ADD;
      it.address   = 32'($urandom_range(FRAMES, 32'hFFFFF) << PAGE_LOG2);
    end else begin
      it.operation = OP_NOP;
    end
    return it;
  endfunction

  // Alloc from an all-used bitmap, then the unused code with all ones and zeros
  task automatic test_empty_memory();
    send_op(OP_ALLOC, 32'h0000_0000);
    send_op(OP_ALLOC, 32'hFFFF_FFFF);
    send_op(OP_NOP,   32'hFFFF_FFFF);
    send_op(OP_NOP,   32'h0000_0000);
    wait_idle();
  endtask

  // Add frame zero and take it back: address 0 with an ok status
  task automatic test_frame_zero();
    send_op(OP_ADD,   32'h0000_0000);
    send_op(OP_ALLOC, 32'h0000_0000);
    send_op(OP_ALLOC, 32'h0000_0000);
    wait_idle();
  endtask

  // Misaligned and out-of-range pages, the last frame, double free
  task automatic test_address_checks();
    send_op(OP_FREE,  32'h0000_0001);
    send_op(OP_ADD,   32'h0000_0800);
    send_op(OP_FREE,  32'hFFFF_FFFF);
    send_op(OP_FREE,  32'(FRAMES << PAGE_LOG2));
    send_op(OP_ADD,   32'hFFFF_F000);
    send_op(OP_FREE,  32'((FRAMES - 1) << PAGE_LOG2));
    send_op(OP_ALLOC, 32'h0000_0000);
    send_op(OP_FREE,  32'h0000_0000);
    send_op(OP_FREE,  32'h0000_0000);
    wait_idle();
  endtask

  // Kernel end at its top, then at a small value, then back to zero
  task automatic test_kernel_end();
    write_kernel_end(16'(FRAMES));
    send_op(OP_ADD, 32'h0000_1000);
    send_op(OP_ADD, 32'((FRAMES - 1) << PAGE_LOG2));
    wait_idle();
    write_kernel_end(16'd5);
    send_op(OP_ADD,   32'(4 << PAGE_LOG2));
    send_op(OP_ADD,   32'(5 << PAGE_LOG2));
    send_op(OP_ALLOC, 32'h0000_0000);
    send_op(OP_ALLOC, 32'h0000_0000);
    wait_idle();
    write_kernel_end(16'd0);
  endtask

  // Several kernel end settings, random items and gaps in each phase
  task automatic test_random_traffic();
    logic [COUNT_W-1:0] ends [PHASES];
    bit                 calm;
    ends[0] = 16'd0;
    ends[1] = 16'(FRAMES);
    ends[2] = 16'($urandom_range(1, 64));
    ends[3] = 16'($urandom_range(0, FRAMES));
    ends[4] = 16'(FRAMES - 1);
    ends[5] = 16'($urandom_range(0, 200));
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_kernel_end(ends[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Run every fourth stretch of 16 items back to back
        calm = ((i >> 4) % 4) == 1;
        send_item(random_item(), calm ? 0 : pick_gap());
        // Hold off the sender until the block has caught up
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 99) < 3) wait_idle();
      end
    end
    wait_idle();
  endtask

  // Add one frame over and over so the counters keep advancing,
  // then step down and back up
  task automatic test_repeated_add();
    write_kernel_end(16'd0);
    for (int i = 0; i < 16; i++) send_op(OP_ADD, 32'(7 << PAGE_LOG2));
    send_op(OP_ALLOC, 32'h0000_0000);
    send_op(OP_FREE,  32'(9 << PAGE_LOG2));
    send_op(OP_FREE,  32'(9 << PAGE_LOG2));
    send_op(OP_ADD,   32'(9 << PAGE_LOG2));
    send_op(OP_ALLOC, 32'h0000_0000);
    wait_idle();
  endtask

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = WORD_FULL;
    free_ctr     = 0;
    total_ctr    = 0;
    kernel_end_q = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Let the clearing pass run before touching the register
    @(posedge clk);
    while (busy) @(posedge clk);
    write_kernel_end(16'd0);

    test_empty_memory();
    test_frame_zero();
    test_address_checks();
    test_kernel_end();
    test_random_traffic();
    test_repeated_add();

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
